/* sv/median_downscale_2x2_assert.svh */
// Assertion macros for the 2x2 median downscaler.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef MEDIAN_DOWNSCALE_2X2_ASSERT_SVH
`define MEDIAN_DOWNSCALE_2X2_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDS2_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MDS2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mds2_pkg.sv */
// Shared types and fixed constants for the 2x2 median downscaler.
// No dependencies; used by median_downscale_2x2.
`default_nettype none

package mds2_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int RESET_SIDE = 8;
  localparam int MIN_SIDE   = 2;

  typedef logic [PIX_W-1:0] pix_t;

  // Lower pixel pair of a block plus its position marks, waiting for the median stage.
  typedef struct packed {
    pix_t left;
    pix_t right;
    logic row_end;
    logic frame_end;
  } blk_t;

endpackage

`default_nettype wire

/* sv/median_downscale_2x2.sv */
// Top level of the 2x2 median downscaler: counters, line store and median stage.
// Depends on mds2_pkg and median_downscale_2x2_assert.svh.
`default_nettype none

`include "median_downscale_2x2_assert.svh"

// Square 8-bit raster image in, half-size image out: each 2x2 block gives the
// truncated mean of its two middle values. One pixel is accepted every clock
// while in_stall is low; a block's result, done at its lower-right pixel, goes
// via the s1 register to an output register holding it while out_stall is high.
// The upper pixel pair of each block waits in a line store of MAX_SIDE/2 16-bit
// entries with one write and one registered read port; it needs no clearing
// pass, since each entry is written in an upper row before the row below reads
// it. Side lengths below 2 act as 2 and above MAX_SIDE as MAX_SIDE; with an odd
// side the last column and row give no results. A write to cfg_side_length
// restarts the frame and should only be made while the block is idle.
module median_downscale_2x2 #(
  parameter int MAX_SIDE = 1024
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [mds2_pkg::CFG_W-1:0]   cfg_side_length,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [mds2_pkg::PIX_W-1:0]   in_pixel,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [mds2_pkg::PIX_W-1:0]   out_value,
  output logic                         out_row_end,
  output logic                         out_frame_end
);

  localparam int CW        = $clog2(MAX_SIDE);
  localparam int SW        = $clog2(MAX_SIDE + 1);
  localparam int DEPTH     = MAX_SIDE / 2;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RESET_EFF = (mds2_pkg::RESET_SIDE > MAX_SIDE) ? MAX_SIDE
                                                               : mds2_pkg::RESET_SIDE;

  // Configuration and position state.
  logic [SW-1:0] side_r, side_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [31:0]   cfg_wide;

  // Input side.
  logic          in_accept;
  logic          in_range;
  logic          last_col;
  logic          last_row;
  logic [SW-1:0] used_w;
  logic [SW-1:0] half_m1;
  logic          blk_row_end;
  logic          blk_frame_end;
  logic [AW-1:0] slot;
  logic          store_wr;
  logic          blk_done;

  mds2_pkg::pix_t held_r;

  // Line store and its registered read data.
  logic [2*mds2_pkg::PIX_W-1:0] pair_mem [DEPTH];
  logic [2*mds2_pkg::PIX_W-1:0] up_pair_r;

  // Median stage.
  logic           s1_v_r;
  mds2_pkg::blk_t s1_r;
  logic           out_free;

  mds2_pkg::pix_t a_w, b_w, c_w, d_w;
  mds2_pkg::pix_t lo_ab, hi_ab, lo_cd, hi_cd, lo_w, hi_w;
  logic [9:0]     sum_w;
  logic [9:0]     mid_w;

  logic           out_valid_r;
  mds2_pkg::pix_t out_value_r;
  logic           out_row_end_r;
  logic           out_frame_end_r;

  assign cfg_ready = 1'b1;

  // Clamp the requested side into the supported range.
  always_comb begin
    cfg_wide = 32'(cfg_side_length);
    if (cfg_wide < 32'(mds2_pkg::MIN_SIDE)) begin
      cfg_wide = 32'(mds2_pkg::MIN_SIDE);
    end else if (cfg_wide > 32'(MAX_SIDE)) begin
      cfg_wide = 32'(MAX_SIDE);
    end
    side_nxt = SW'(cfg_wide);
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_v_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign used_w   = side_r & ~SW'(1);
  assign half_m1  = (side_r >> 1) - SW'(1);
  assign in_range = (SW'(col_r) < used_w) && (SW'(row_r) < used_w);
  assign last_col = SW'(col_r) == (side_r - SW'(1));
  assign last_row = SW'(row_r) == (side_r - SW'(1));
  assign slot     = AW'(col_r >> 1);

  assign blk_row_end   = SW'(col_r >> 1) == half_m1;
  assign blk_frame_end = blk_row_end && (SW'(row_r >> 1) == half_m1);

  // An odd column in an even row finishes an upper pair; in an odd row it finishes a block.
  assign store_wr = in_accept && in_range && col_r[0] && !row_r[0];
  assign blk_done = in_accept && in_range && col_r[0] && row_r[0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_valid && cfg_ready) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SW'(RESET_EFF);
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        side_r <= side_nxt;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_range && !col_r[0]) begin
      held_r <= in_pixel;
    end
  end

  // Line store: a write for each finished upper pair and a registered read per accepted pixel.
  always_ff @(posedge clk) begin
    if (store_wr) begin
      pair_mem[slot] <= {in_pixel, held_r};
    end
    if (in_accept) begin
      up_pair_r <= pair_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= blk_done;
    end else if (out_free) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_done) begin
      s1_r.left      <= held_r;
      s1_r.right     <= in_pixel;
      s1_r.row_end   <= blk_row_end;
      s1_r.frame_end <= blk_frame_end;
    end
  end

  // Drop the smallest and largest of the four; the output register keeps half of what is left.
  always_comb begin
    a_w   = up_pair_r[mds2_pkg::PIX_W-1:0];
    b_w   = up_pair_r[2*mds2_pkg::PIX_W-1:mds2_pkg::PIX_W];
    c_w   = s1_r.left;
    d_w   = s1_r.right;
    lo_ab = (a_w < b_w) ? a_w : b_w;
    hi_ab = (a_w < b_w) ? b_w : a_w;
    lo_cd = (c_w < d_w) ? c_w : d_w;
    hi_cd = (c_w < d_w) ? d_w : c_w;
    lo_w  = (lo_ab < lo_cd) ? lo_ab : lo_cd;
    hi_w  = (hi_ab > hi_cd) ? hi_ab : hi_cd;
    sum_w = 10'(a_w) + 10'(b_w) + 10'(c_w) + 10'(d_w);
    mid_w = sum_w - 10'(lo_w) - 10'(hi_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_v_r) begin
      out_value_r     <= mid_w[mds2_pkg::PIX_W:1];
      out_row_end_r   <= s1_r.row_end;
      out_frame_end_r <= s1_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  `MDS2_ASSERT_NOW(a_side_range, 1'b1,
    (side_r >= SW'(mds2_pkg::MIN_SIDE)) && (32'(side_r) <= 32'(MAX_SIDE)),
    "side register outside its supported range")
  `MDS2_ASSERT_NOW(a_pos_range, 1'b1,
    (SW'(col_r) < side_r) && (SW'(row_r) < side_r),
    "pixel position beyond the configured side")
  `MDS2_ASSERT_NOW(a_frame_row, out_valid_r && out_frame_end_r, out_row_end_r,
    "frame end without row end")
  `MDS2_ASSERT_NEXT(a_s1_hold, s1_v_r && !out_free, s1_v_r,
    "pending block lost while the output was blocked")

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the 2x2 median downscaler median_downscale_2x2.
// Depends on mds2_pkg and the RTL only; it drives pixel streams over several side
// lengths and checks every pooled result against a predictor kept in step here.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_SIDE   = 1024;
  localparam int PAIR_DEPTH = MAX_SIDE / 2;
  localparam int SETTLE     = 8;     // cycles the pipeline may still be busy after a last result
  localparam int WATCHDOG   = 4000;  // cycles without any accepted request
  localparam int ITEM_GOAL  = 1250;  // pixels sent before the final quiet phases
  localparam int PHASE_CAP  = 300;   // longest pixel run of one small-side phase
  localparam int NUM_ROWS   = 24;

  typedef mds2_pkg::pix_t pix_t;
  typedef logic [mds2_pkg::CFG_W-1:0] side_t;

  typedef struct packed {
    pix_t value;
    logic row_end;
    logic frame_end;
  } median_t;

  typedef struct packed {
    bit   typed;
    pix_t value;
    logic row_end;
    logic frame_end;
    pix_t px;
  } directed_row_t;

  // Six complete 2x2 frames; the lower-right pixel of each of the first three carries a typed result.
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd0},   {1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd0},   {1'b1, 8'd0, 1'b1, 1'b1, 8'd0},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd255}, {1'b0, 8'd0, 1'b0, 1'b0, 8'd255},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd255}, {1'b1, 8'd255, 1'b1, 1'b1, 8'd255},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd0},   {1'b0, 8'd0, 1'b0, 1'b0, 8'd255},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd0},   {1'b1, 8'd127, 1'b1, 1'b1, 8'd255},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd255}, {1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd255}, {1'b0, 8'd0, 1'b0, 1'b0, 8'd1},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd1},   {1'b0, 8'd0, 1'b0, 1'b0, 8'd2},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd4},   {1'b0, 8'd0, 1'b0, 1'b0, 8'd8},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd128}, {1'b0, 8'd0, 1'b0, 1'b0, 8'd64},
    {1'b0, 8'd0, 1'b0, 1'b0, 8'd32},  {1'b0, 8'd0, 1'b0, 1'b0, 8'd16}
  };

  logic  clk;
  logic  rst_n;
  logic  cfg_valid;
  logic  cfg_ready;
  side_t cfg_side_length;
  logic  in_valid;
  logic  in_stall;
  pix_t  in_pixel;
  logic  out_valid;
  logic  out_stall;
  pix_t  out_value;
  logic  out_row_end;
  logic  out_frame_end;

  median_downscale_2x2 #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_side_length(cfg_side_length),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end)
  );

  // Predictor state.
  side_t       side_reg;
  int unsigned col_pos;
  int unsigned row_pos;
  pix_t        left_px;
  logic [15:0] upper_pairs [PAIR_DEPTH];

  median_t     median_q [$];
  int          mismatch_count;
  bit          gaps_on;
  bit          stall_on;
  int unsigned sent_items;
  int unsigned stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_side(input side_t s);
    if (s < mds2_pkg::MIN_SIDE) return mds2_pkg::MIN_SIDE;
    if (s > MAX_SIDE) return MAX_SIDE;
    return s;
  endfunction

  // The middle two of four values are the larger of the two pair minima and the
  // smaller of the two pair maxima.
  function automatic pix_t mid_mean(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
    pix_t     lo_ab, hi_ab, lo_cd, hi_cd, mid_lo, mid_hi;
    logic [8:0] total;
    lo_ab  = (a < b) ? a : b;
    hi_ab  = (a < b) ? b : a;
    lo_cd  = (c < d) ? c : d;
    hi_cd  = (c < d) ? d : c;
    mid_lo = (lo_ab > lo_cd) ? lo_ab : lo_cd;
    mid_hi = (hi_ab < hi_cd) ? hi_ab : hi_cd;
    total  = 9'(mid_lo) + 9'(mid_hi);
    return total[8:1];
  endfunction

  task automatic predict_pixel(input pix_t p, output bit has, output median_t m);
    int unsigned e, half, slot;
    logic [15:0] up;
    e    = clamp_side(side_reg);
    half = e / 2;
    slot = (col_pos >> 1) % PAIR_DEPTH;
    has  = 1'b0;
    m    = '0;
    if (col_pos < 2 * half && row_pos < 2 * half) begin
      if ((col_pos & 1) == 0) begin
        left_px = p;
      end else if ((row_pos & 1) == 0) begin
        upper_pairs[slot] = {p, left_px};
      end else begin
        up          = upper_pairs[slot];
        m.value     = mid_mean(up[7:0], up[15:8], left_px, p);
        m.row_end   = (col_pos >> 1) == half - 1;
        m.frame_end = m.row_end && ((row_pos >> 1) == half - 1);
        has         = 1'b1;
      end
    end
    col_pos++;
    if (col_pos >= e) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= e) row_pos = 0;
    end
  endtask

  // One pixel request; a typed expectation replaces the predicted one where given.
  task automatic send_pixel(input pix_t p, input bit typed, input median_t typed_m);
    bit      has;
    median_t m;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
    sent_items++;
    predict_pixel(p, has, m);
    if (has) median_q.insert(median_q.size(), typed ? typed_m : m);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_side(input side_t s);
    hold_until_drained();
    // Pixels in a dropped column or row give no result but may still be in flight.
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_side_length <= s;
    do @(posedge clk); while (!cfg_ready);
    side_reg = s;
    col_pos  = 0;
    row_pos  = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic pix_t pick_pixel(input pix_t prev);
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return prev;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Small sides run one or two frames, sometimes with a partial frame cut short by
  // the next register write, and never more than PHASE_CAP pixels; large sides only
  // reach into the first lower row.
  task automatic run_phase(input side_t s, input bit quiet);
    int unsigned e, frame, n;
    pix_t        p;
    gaps_on  = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    stall_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
    write_side(s);
    e     = clamp_side(s);
    frame = e * e;
    if (frame <= 4096) begin
      n = frame * $urandom_range(1, 2);
      if (!quiet && $urandom_range(0, 1) == 1) n += $urandom_range(1, frame - 1);
      if (n > PHASE_CAP) n = PHASE_CAP;
    end else begin
      n = e + $urandom_range(2, 16);
    end
    p = 8'd0;
    for (int unsigned i = 0; i < n; i++) begin
      p = pick_pixel(p);
      if (!quiet && $urandom_range(0, 299) == 0) hold_until_drained();
      send_pixel(p, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    median_t exp_m;
    if (rst_n && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        $display("%0t: result with none expected: value %0d row_end %0b frame_end %0b",
                 $time, out_value, out_row_end, out_frame_end);
        mismatch_count++;
      end else begin
        exp_m = median_q.pop_front();
        if (out_value !== exp_m.value) begin
          $display("%0t: value expected %0d, got %0d", $time, exp_m.value, out_value);
          mismatch_count++;
        end
        if (out_row_end !== exp_m.row_end) begin
          $display("%0t: row_end expected %0b, got %0b", $time, exp_m.row_end, out_row_end);
          mismatch_count++;
        end
        if (out_frame_end !== exp_m.frame_end) begin
          $display("%0t: frame_end expected %0b, got %0b",
                   $time, exp_m.frame_end, out_frame_end);
          mismatch_count++;
        end
      end
    end
  end

  // Output stalls come in bursts of random length while stall_on is set.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 17);
    end
  end

  // Counts cycles in which no request of any channel is taken.
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG);
      $display("median_downscale_2x2 test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    side_t   s;
    median_t typed_m;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_side_length = '0;
    in_valid        = 1'b0;
    in_pixel        = '0;
    out_stall       = 1'b0;
    gaps_on         = 1'b0;
    stall_on        = 1'b0;
    mismatch_count  = 0;
    sent_items      = 0;
    side_reg        = side_t'(mds2_pkg::RESET_SIDE);
    col_pos         = 0;
    row_pos         = 0;
    left_px         = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A side of zero acts as two, so every four pixels close a frame.
    write_side('0);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < NUM_ROWS; i++) begin
      typed_m = {DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].row_end, DIRECTED_ROWS[i].frame_end};
      send_pixel(DIRECTED_ROWS[i].px, DIRECTED_ROWS[i].typed, typed_m);
      if (i == 11) hold_until_drained();
    end

    run_phase(11'd1, 1'b0);
    run_phase(11'd3, 1'b0);
    run_phase(11'd2, 1'b0);
    run_phase(11'd5, 1'b0);
    run_phase(11'd2047, 1'b0);
    run_phase(11'd7, 1'b0);
    while (sent_items < ITEM_GOAL) begin
      s = ($urandom_range(0, 9) == 0) ? side_t'($urandom_range(17, 24))
                                      : side_t'($urandom_range(2, 16));
      run_phase(s, 1'b0);
    end
    run_phase(11'd6, 1'b1);
    run_phase(11'd4, 1'b1);

    hold_until_drained();
    repeat (4 * SETTLE) @(posedge clk);
    if (mismatch_count == 0 && median_q.size() == 0) begin
      $display("median_downscale_2x2 test passed");
    end else begin
      if (median_q.size() != 0) $display("%0d expected results never arrived", median_q.size());
      $display("median_downscale_2x2 test failed");
    end
    $finish;
  end

endmodule
